// ===== design/ebs_pkg.sv =====
// Shared constants, register codes and reciprocal table for the 3x3 edge-aware box smoother.
// No dependencies; the divider and core refer to it by scoped names, the bench imports it.
package ebs_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int ROW_LIMIT   = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
   localparam int COL_BITS    = 12;
   localparam int DIM_BITS    = 13;
   localparam int CSR_IDX_BITS = 2;
   localparam int SUM_BITS    = 20;
   localparam int CNT_BITS    = 4;
   localparam int RECIP_BITS  = 24;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   localparam logic [DIM_BITS-1:0] ROW_WIDTH_RESET    = 13'd2048;
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 13'd2048;

   // floor(2^24 / d), one short of 2^24 for d = 1; the divider corrects by one.
   function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] d);
      case (d)
         4'd1:    recip = RECIP_BITS'((1 << RECIP_BITS) - 1);
         4'd2:    recip = RECIP_BITS'((1 << RECIP_BITS) / 2);
         4'd3:    recip = RECIP_BITS'((1 << RECIP_BITS) / 3);
         4'd4:    recip = RECIP_BITS'((1 << RECIP_BITS) / 4);
         4'd5:    recip = RECIP_BITS'((1 << RECIP_BITS) / 5);
         4'd6:    recip = RECIP_BITS'((1 << RECIP_BITS) / 6);
         4'd7:    recip = RECIP_BITS'((1 << RECIP_BITS) / 7);
         4'd8:    recip = RECIP_BITS'((1 << RECIP_BITS) / 8);
         4'd9:    recip = RECIP_BITS'((1 << RECIP_BITS) / 9);
         default: recip = '0;
      endcase
   endfunction

endpackage

// ===== design/ebs_line_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds both line buffers side by side; no package dependency.
module ebs_line_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/ebs_div.sv =====
// Two-stage divide of a neighbourhood sum by a small count via reciprocal multiply.
// Depends on ebs_pkg for widths and the reciprocal table.
module ebs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ebs_pkg::SUM_BITS-1:0] num,
   input  logic [ebs_pkg::CNT_BITS-1:0] den,
   output logic                         done,
   output logic [ebs_pkg::SUM_BITS-1:0] quot
);

   localparam int PROD_BITS = ebs_pkg::SUM_BITS + ebs_pkg::RECIP_BITS;
   localparam int QD_BITS   = ebs_pkg::SUM_BITS + ebs_pkg::CNT_BITS;

   logic                         vld1_ff, vld2_ff;
   logic [PROD_BITS-1:0]         prod_ff;
   logic [ebs_pkg::SUM_BITS-1:0] num_ff;
   logic [ebs_pkg::CNT_BITS-1:0] den_ff;
   logic [ebs_pkg::SUM_BITS-1:0] quot_ff, quot_in;

   logic [ebs_pkg::SUM_BITS-1:0] q0;
   logic [QD_BITS-1:0]           qd;
   logic [QD_BITS-1:0]           rem;

   // estimate is exact or one low
   always_comb begin
      q0      = prod_ff[PROD_BITS-1:ebs_pkg::RECIP_BITS];
      qd      = QD_BITS'(q0) * QD_BITS'(den_ff);
      rem     = QD_BITS'(num_ff) - qd;
      quot_in = (rem >= QD_BITS'(den_ff)) ? q0 + 1'b1 : q0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= start;
         vld2_ff <= vld1_ff;
      end
      prod_ff <= PROD_BITS'(num) * PROD_BITS'(ebs_pkg::recip(den));
      num_ff  <= num;
      den_ff  <= den;
      quot_ff <= quot_in;
   end

   assign done = vld2_ff;
   assign quot = quot_ff;

endmodule

// ===== design/edge_aware_box_smooth_3x3_core.sv =====
// 3x3 edge-aware box smoother: raster height samples in, neighbourhood means out.
// A taken beat stalls the input through the load and sum states and, for each of up
// to two results, the divide, wait and send states, plus any output stall; ignored
// beats do not stall the input. Both results of a beat go through the shared divider.
// The stall covers the line-buffer read/write round trip and the shared divider.
// Reset (synchronous, active high) clears counters, window and handshakes; line RAM undefined.
module edge_aware_box_smooth_3x3_core (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [ebs_pkg::SAMPLE_BITS-1:0]  req_sample,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ebs_pkg::SAMPLE_BITS-1:0]  rsp_smoothed,
   output logic [ebs_pkg::COL_BITS-1:0]     rsp_out_row,
   output logic [ebs_pkg::COL_BITS-1:0]     rsp_out_col,
   output logic                             rsp_last,
   output logic                             rsp_frame_done,
   // configuration
   input  logic                             csr_we,
   input  logic [ebs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ebs_pkg::DIM_BITS-1:0]     csr_wdata
);

   localparam int SB = ebs_pkg::SAMPLE_BITS;
   localparam int CB = ebs_pkg::COL_BITS;
   localparam int DB = ebs_pkg::DIM_BITS;
   localparam int AB = ebs_pkg::ADDR_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SUM, S_DIV, S_WAIT, S_SEND
   } state_type;

   state_type state_ff;

   // configuration and position
   logic [DB-1:0] row_width_ff, frame_height_ff;
   logic [CB-1:0] col_ff;
   logic [DB-1:0] row_ff;

   // window: [row][col], row 0 oldest line, col 2 newest column
   logic [SB-1:0] win_ff [3][3];

   // item being worked on
   logic          drain_ff;
   logic [SB-1:0] nv_ff;
   logic [CB-1:0] c_ff;
   logic [DB-1:0] r_ff;
   logic          pend_b_ff, sel_b_ff;
   logic [ebs_pkg::SUM_BITS-1:0] na_ff, nb_ff;
   logic [ebs_pkg::CNT_BITS-1:0] ca_ff, cb_ff;

   // result register
   logic          rsp_valid_ff;
   logic [SB-1:0] smoothed_ff;
   logic [CB-1:0] out_row_ff, out_col_ff;
   logic          last_ff, frame_done_ff;

   // effective sizes and clamped position
   logic [DB-1:0] w_eff, h_eff, w_m1;
   logic [CB-1:0] c_cl;
   logic [DB-1:0] r_cl;
   logic          eligible;
   logic          req_take;

   always_comb begin
      if (row_width_ff == '0) begin
         w_eff = DB'(1);
      end else if (row_width_ff > DB'(ebs_pkg::MAX_WIDTH)) begin
         w_eff = DB'(ebs_pkg::MAX_WIDTH);
      end else begin
         w_eff = row_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = DB'(1);
      end else if (frame_height_ff > DB'(ebs_pkg::ROW_LIMIT)) begin
         h_eff = DB'(ebs_pkg::ROW_LIMIT);
      end else begin
         h_eff = frame_height_ff;
      end
      w_m1     = w_eff - 1'b1;
      c_cl     = ({1'b0, col_ff} >= w_eff) ? w_m1[CB-1:0] : col_ff;
      r_cl     = (row_ff > h_eff) ? h_eff : row_ff;
      // drain ticks only in the virtual row, samples only in real rows
      eligible = ((req_op == ebs_pkg::OP_DRAIN) == (r_cl >= h_eff));
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // line buffers: [2*SB-1:SB] upper (row r-2), [SB-1:0] middle (row r-1)
   logic          ram_we;
   logic [2*SB-1:0] ram_rdata;

   assign ram_we = (state_ff == S_LOAD) && !drain_ff;

   ebs_line_ram #(
      .DEPTH (ebs_pkg::MAX_WIDTH),
      .WIDTH (2 * SB)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (c_ff[AB-1:0]),
      .wdata ({ram_rdata[SB-1:0], nv_ff}),
      .raddr (c_cl[AB-1:0]),
      .rdata (ram_rdata)
   );

   // neighbourhood sums; taps outside the map are masked out
   logic [2:0] row_ok, col_ok;
   logic [ebs_pkg::SUM_BITS-1:0] sum_a, sum_b;
   logic [ebs_pkg::CNT_BITS-1:0] cnt_a, cnt_b;
   logic emit_a, emit_b;

   always_comb begin
      row_ok[0] = (r_ff >= DB'(2));
      row_ok[1] = (r_ff >= DB'(1));
      row_ok[2] = (r_ff <  h_eff);
      col_ok[0] = (c_ff >= CB'(2));
      col_ok[1] = (c_ff >= CB'(1));
      col_ok[2] = 1'b1;
      sum_a = '0;
      sum_b = '0;
      cnt_a = '0;
      cnt_b = '0;
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            if (row_ok[k] && col_ok[m]) begin
               sum_a = sum_a + ebs_pkg::SUM_BITS'(win_ff[k][m]);
               cnt_a = cnt_a + 1'b1;
               if (m >= 1) begin
                  sum_b = sum_b + ebs_pkg::SUM_BITS'(win_ff[k][m]);
                  cnt_b = cnt_b + 1'b1;
               end
            end
         end
      end
      emit_a = row_ok[1] && col_ok[1];
      emit_b = row_ok[1] && ({1'b0, c_ff} == w_m1);
   end

   // shared divider
   logic                         div_start, div_done;
   logic [ebs_pkg::SUM_BITS-1:0] div_quot;

   assign div_start = (state_ff == S_DIV);

   ebs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sel_b_ff ? nb_ff : na_ff),
      .den   (sel_b_ff ? cb_ff : ca_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         row_width_ff    <= ebs_pkg::ROW_WIDTH_RESET;
         frame_height_ff <= ebs_pkg::FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         pend_b_ff       <= 1'b0;
         sel_b_ff        <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               win_ff[k][m] <= '0;
            end
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               // RAM read at c_cl is issued this cycle
               if (req_take && eligible) begin
                  drain_ff <= (req_op == ebs_pkg::OP_DRAIN);
                  nv_ff    <= (req_op == ebs_pkg::OP_DRAIN) ? '0 : req_sample;
                  c_ff     <= c_cl;
                  r_ff     <= r_cl;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               for (int k = 0; k < 3; k++) begin
                  win_ff[k][0] <= win_ff[k][1];
                  win_ff[k][1] <= win_ff[k][2];
               end
               win_ff[0][2] <= ram_rdata[2*SB-1:SB];
               win_ff[1][2] <= ram_rdata[SB-1:0];
               win_ff[2][2] <= nv_ff;
               if ({1'b0, c_ff} + 1'b1 >= w_eff) begin
                  col_ff <= '0;
                  row_ff <= (r_ff >= h_eff) ? '0 : r_ff + 1'b1;
               end else begin
                  col_ff <= c_ff + 1'b1;
                  row_ff <= r_ff;
               end
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // rounded mean: numerator carries half the count
               na_ff     <= sum_a + ebs_pkg::SUM_BITS'(cnt_a >> 1);
               nb_ff     <= sum_b + ebs_pkg::SUM_BITS'(cnt_b >> 1);
               ca_ff     <= cnt_a;
               cb_ff     <= cnt_b;
               pend_b_ff <= emit_b;
               if (emit_a) begin
                  sel_b_ff <= 1'b0;
                  state_ff <= S_DIV;
               end else if (emit_b) begin
                  sel_b_ff <= 1'b1;
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_done) begin
                  rsp_valid_ff  <= 1'b1;
                  smoothed_ff   <= div_quot[SB-1:0];
                  out_row_ff    <= CB'(r_ff - 1'b1);
                  out_col_ff    <= sel_b_ff ? c_ff : c_ff - 1'b1;
                  last_ff       <= sel_b_ff || !pend_b_ff;
                  frame_done_ff <= sel_b_ff && (r_ff == h_eff);
                  state_ff      <= S_SEND;
               end
            end
            S_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (!sel_b_ff && pend_b_ff) begin
                     sel_b_ff <= 1'b1;
                     state_ff <= S_DIV;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // a write to the width or height register restarts the frame
         if (csr_we) begin
            case (csr_index)
               ebs_pkg::CSR_ROW_WIDTH: begin
                  row_width_ff <= csr_wdata;
                  col_ff       <= '0;
                  row_ff       <= '0;
                  for (int k = 0; k < 3; k++) begin
                     for (int m = 0; m < 3; m++) begin
                        win_ff[k][m] <= '0;
                     end
                  end
               end
               ebs_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata;
                  col_ff          <= '0;
                  row_ff          <= '0;
                  for (int k = 0; k < 3; k++) begin
                     for (int m = 0; m < 3; m++) begin
                        win_ff[k][m] <= '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_smoothed   = smoothed_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_last       = last_ff;
   assign rsp_frame_done = frame_done_ff;

endmodule

// ===== tb/edge_aware_box_smooth_3x3_core_tb.sv =====
// Self-checking bench for the edge-aware 3x3 box smoother: stimulus, scoreboard and predictor.
// Depends on ebs_pkg and edge_aware_box_smooth_3x3_core only; reads and writes no files.
`timescale 1ns / 1ps

module edge_aware_box_smooth_3x3_core_tb;
   import ebs_pkg::*;

   // ---------------------------------------------------------------- constants
   localparam int RANDOM_BEATS  = 1500;    // well-formed beats in the random part
   localparam int SETTLE_CYCLES = 16;      // beats with no result may still be in flight
   localparam int LONG_HOLD     = 300;     // receiver hold-off, long enough to back up
   localparam int DRAIN_GUARD   = 200000;  // bound on any wait for results
   // Bound on a whole run: a 4096-wide and a 4096-high frame, plus ~1500 random beats
   // each waiting out long gaps and stalls.
   localparam int CYCLE_LIMIT   = 2000000;

   // indexes with no register behind them; writes there must change nothing
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   // one smoothed result as it leaves the block
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smoothed;
      logic [COL_BITS-1:0]    out_row;
      logic [COL_BITS-1:0]    out_col;
      logic                   last;
      logic                   frame_done;
   } smoothed_px_t;

   // one row of the directed table: a register write or an input beat
   typedef struct packed {
      bit                      is_write;
      logic [CSR_IDX_BITS-1:0] idx;
      logic [DIM_BITS-1:0]     value;
      logic                    op;
      logic [SAMPLE_BITS-1:0]  smp;
      bit                      typed;  // mean below is known by inspection
      logic [SAMPLE_BITS-1:0]  mean;
   } directed_step_t;

   localparam int DIRECTED_ROWS = 35;

   // ---------------------------------------------------------------- DUT signals
   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_op;
   logic [SAMPLE_BITS-1:0]  req_sample;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [SAMPLE_BITS-1:0]  rsp_smoothed;
   logic [COL_BITS-1:0]     rsp_out_row;
   logic [COL_BITS-1:0]     rsp_out_col;
   logic                    rsp_last;
   logic                    rsp_frame_done;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [DIM_BITS-1:0]     csr_wdata;

   edge_aware_box_smooth_3x3_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_smoothed   (rsp_smoothed),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_last       (rsp_last),
      .rsp_frame_done (rsp_frame_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- bench state
   // predictor copy of the block
   logic [DIM_BITS-1:0]    width_reg;
   logic [DIM_BITS-1:0]    height_reg;
   logic [SAMPLE_BITS-1:0] older_row [MAX_WIDTH] = '{default: '0};  // row r-2
   logic [SAMPLE_BITS-1:0] newer_row [MAX_WIDTH] = '{default: '0};  // row r-1
   logic [SAMPLE_BITS-1:0] window_px [3][3];
   int unsigned            col_pos;
   int unsigned            row_pos;

   smoothed_px_t           awaited_pixels [$];   // expected results, oldest first

   // stimulus side
   bit                     idle_on;
   bit                     typed_on;
   logic [SAMPLE_BITS-1:0] typed_mean;
   int unsigned            cur_w;
   int unsigned            cur_h;
   int                     hold_off_requests;
   int                     hold_off_served;

   // bookkeeping
   int                     failures;
   int                     beats_taken;
   int                     beats_ignored;
   int                     results_seen;
   int                     reg_writes;
   int                     useful_beats;
   longint                 cycle_count;

   // Directed table.  Typed means: all-white maps give white everywhere; a 1x1
   // map returns its one sample; a 1-wide 2-high map of 0 and 1 averages two
   // taps and rounds the half up.
   directed_step_t directed_steps [DIRECTED_ROWS] = '{
      // drain tick while rows remain (reset state, 2048 x 2048): ignored
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'h5A5A, 1'b0, 16'h0000},
      // zero registers act as a 1x1 map
      '{1'b1, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b1, CSR_FRAME_HEIGHT, 13'd0, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
      // sample during the drain row: ignored
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h1234, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'h0000, 1'b1, 16'hFFFF},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'hFFFF, 1'b1, 16'h0000},
      // single column, two rows: row-end result from column 0
      '{1'b1, CSR_ROW_WIDTH,    13'd1, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b1, CSR_FRAME_HEIGHT, 13'd2, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h0001, 1'b1, 16'h0001},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'h0000, 1'b1, 16'h0001},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'h0000, 1'b0, 16'h0000},
      // 3 x 2 all white: corners, edges, two results at each row end
      '{1'b1, CSR_ROW_WIDTH,    13'd3, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b1, CSR_FRAME_HEIGHT, 13'd2, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'hFFFF, 1'b1, 16'hFFFF},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'h0000, 1'b1, 16'hFFFF},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_DRAIN,  16'hFFFF, 1'b1, 16'hFFFF},
      // 3 x 3 with mixed values, checked by the predictor
      '{1'b1, CSR_FRAME_HEIGHT, 13'd3, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h8000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h0001, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hAAAA, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h5555, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'hFFFE, 1'b0, 16'h0000},
      // writes to unused indexes must not restart the frame
      '{1'b1, CSR_SPARE_LO,     13'd5, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b1, CSR_SPARE_HI,     13'h1FFF, OP_SAMPLE, 16'h0000, 1'b0, 16'h0000},
      '{1'b0, CSR_ROW_WIDTH,    13'd0, OP_SAMPLE, 16'h0F0F, 1'b0, 16'h0000}
   };

   // ---------------------------------------------------------------- helpers
   // register value to effective size: 0 acts as 1, above the ceiling clamps
   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned ceiling);
      if (v == 0) return 1;
      if (v > ceiling) return ceiling;
      return v;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // extremes are frequent so that flat areas and saturation are well hit
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return SAMPLE_BITS'($urandom);
   endfunction

   function automatic void restart_frame();
      col_pos   = 0;
      row_pos   = 0;
      window_px = '{default: '0};
   endfunction

   // mean of the in-map taps around window column mid; r is the newest window
   // row, c the newest window column, col the column reported
   function automatic smoothed_px_t neighbourhood_mean(input int unsigned mid, r, c, h, col);
      smoothed_px_t px;
      int unsigned  k, m, total, taps;
      bit           row_in;
      total = 0;
      taps  = 0;
      for (k = 0; k < 3; k++) begin
         row_in = (k == 0) ? (r >= 2) : (k == 1) ? (r >= 1) : (r < h);
         if (row_in) begin
            for (m = mid - 1; m <= mid + 1 && m < 3; m++) begin
               if (c + m >= 2) begin
                  total += window_px[k][m];
                  taps++;
               end
            end
         end
      end
      px.smoothed   = (taps == 0) ? '0 : SAMPLE_BITS'((total + taps / 2) / taps);
      px.out_row    = COL_BITS'(r - 1);
      px.out_col    = COL_BITS'(col);
      px.last       = 1'b0;
      px.frame_done = 1'b0;
      return px;
   endfunction

   // advance the predictor by one taken beat and queue the results it causes
   function automatic void absorb_beat(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                                       input bit typed, input logic [SAMPLE_BITS-1:0] mean);
      int unsigned            w, h, c, r, n, k;
      logic [SAMPLE_BITS-1:0] nv;
      smoothed_px_t           made [2];
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, ROW_LIMIT);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos > h) ? h : row_pos;
      // drain ticks belong to the drain row only, samples to the map rows only
      if ((op == OP_DRAIN) != (r >= h)) begin
         beats_ignored++;
         return;
      end
      beats_taken++;
      nv = (op == OP_DRAIN) ? '0 : smp;
      for (k = 0; k < 3; k++) begin
         window_px[k][0] = window_px[k][1];
         window_px[k][1] = window_px[k][2];
      end
      window_px[0][2] = older_row[c];
      window_px[1][2] = newer_row[c];
      window_px[2][2] = nv;
      if (op == OP_SAMPLE) begin
         older_row[c] = newer_row[c];
         newer_row[c] = nv;
      end
      n = 0;
      if (r >= 1) begin
         if (c >= 1) begin
            made[n] = neighbourhood_mean(1, r, c, h, c - 1);
            n++;
         end
         if (c == w - 1) begin
            made[n]            = neighbourhood_mean(2, r, c, h, c);
            made[n].frame_done = (r == h);
            n++;
         end
         if (n > 0) made[n - 1].last = 1'b1;
      end
      for (k = 0; k < n; k++) begin
         if (typed) made[k].smoothed = mean;
         awaited_pixels.push_back(made[k]);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   function automatic void check_field(input string what, input int unsigned row, col,
                                       input logic [31:0] want, input logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch at row %0d col %0d, expected %0d, got %0d",
                  $time, what, row, col, want, seen);
         failures++;
      end
   endfunction

   // ---------------------------------------------------------------- scoreboard
   // Everything the block takes or gives is seen here, at the rising edge and
   // in one process: the check of a result always precedes the prediction of a
   // beat taken at the same edge.
   always @(posedge clock) begin : pixel_monitor
      smoothed_px_t want;
      if (reset) begin
         width_reg  = ROW_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         restart_frame();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_pixels.size() == 0) begin
               $display("%0t: result with nothing expected, smoothed %0d at row %0d col %0d",
                        $time, rsp_smoothed, rsp_out_row, rsp_out_col);
               failures++;
            end else begin
               want = awaited_pixels.pop_front();
               results_seen++;
               check_field("smoothed",   want.out_row, want.out_col, want.smoothed,
                           rsp_smoothed);
               check_field("out_row",    want.out_row, want.out_col, want.out_row,
                           rsp_out_row);
               check_field("out_col",    want.out_row, want.out_col, want.out_col,
                           rsp_out_col);
               check_field("last",       want.out_row, want.out_col, want.last, rsp_last);
               check_field("frame_done", want.out_row, want.out_col, want.frame_done,
                           rsp_frame_done);
            end
         end
         if (csr_we) begin
            reg_writes++;
            case (csr_index)
               CSR_ROW_WIDTH: begin
                  width_reg = csr_wdata;
                  restart_frame();
               end
               CSR_FRAME_HEIGHT: begin
                  height_reg = csr_wdata;
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            absorb_beat(req_op, req_sample, typed_on, typed_mean);
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d results outstanding", $time,
                  awaited_pixels.size());
         $display("edge_aware_box_smooth_3x3_core verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- result stall
   // Random stalls while idling is on; a requested hold-off is served whatever
   // the idling mode and lasts long enough to back the block up to its input.
   initial begin : rsp_stall_gen
      int span;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_served != hold_off_requests) begin
            hold_off_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(99) < 25) begin
            span = gap_len();
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- driving tasks
   // Offer one beat from the next falling edge, or after a random gap while idling is on, and hold it until taken.
   task automatic send_beat(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                            input bit typed = 1'b0,
                            input logic [SAMPLE_BITS-1:0] mean = '0);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(99) < 20) begin
         gap = gap_len();
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_sample <= smp;
      typed_on   = typed;
      typed_mean = mean;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering, wait for every expected result, then let stray work settle.
   task automatic wait_results_drained();
      int guard;
      @(negedge clock);
      req_valid <= 1'b0;
      typed_on  = 1'b0;
      guard     = 0;
      while (awaited_pixels.size() != 0 && guard < DRAIN_GUARD) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_ROW_WIDTH) cur_w = clamp_dim(val, MAX_WIDTH);
      else if (idx == CSR_FRAME_HEIGHT) cur_h = clamp_dim(val, ROW_LIMIT);
   endtask

   // A well-formed frame: w*h samples then w drain ticks, with the odd stray
   // beat of the wrong kind mixed in.  A cut frame stops part way.
   task automatic send_frame(input int unsigned w, h, input bit cut_short);
      int unsigned total, stop_at, idx;
      bit          in_map;
      total   = w * h + w;
      stop_at = cut_short ? $urandom_range(total - 1) : total;
      for (idx = 0; idx < stop_at; idx++) begin
         in_map = (idx < w * h);
         if ($urandom_range(99) < 6)
            send_beat(in_map ? OP_DRAIN : OP_SAMPLE, SAMPLE_BITS'($urandom));
         send_beat(in_map ? OP_SAMPLE : OP_DRAIN, pick_sample());
         useful_beats++;
      end
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin : stimulus
      int             i, roll, frames, phase;
      int unsigned    w_raw, h_raw;
      bit             cut;
      directed_step_t step;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_op     = OP_SAMPLE;
      req_sample = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_ROW_WIDTH;
      csr_wdata  = '0;
      idle_on    = 1'b1;
      typed_on   = 1'b0;
      typed_mean = '0;
      cur_w      = ROW_WIDTH_RESET;
      cur_h      = FRAME_HEIGHT_RESET;
      hold_off_requests = 0;
      hold_off_served   = 0;
      failures      = 0;
      beats_taken   = 0;
      beats_ignored = 0;
      results_seen  = 0;
      reg_writes    = 0;
      useful_beats  = 0;
      cycle_count   = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, register writes only once the block is idle
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         step = directed_steps[i];
         if (step.is_write) begin
            wait_results_drained();
            write_reg(step.idx, step.value);
         end else begin
            send_beat(step.op, step.smp, step.typed, step.mean);
         end
      end

      // largest sizes, one frame each, straight through with no idling:
      // an over-range width (acts as 4096) and an over-range height
      wait_results_drained();
      idle_on = 1'b0;
      write_reg(CSR_ROW_WIDTH, {DIM_BITS{1'b1}});
      write_reg(CSR_FRAME_HEIGHT, DIM_BITS'(1));
      send_frame(cur_w, cur_h, 1'b0);
      wait_results_drained();
      write_reg(CSR_ROW_WIDTH, DIM_BITS'(1));
      write_reg(CSR_FRAME_HEIGHT, {DIM_BITS{1'b1}});
      send_frame(cur_w, cur_h, 1'b0);

      // random phases of small maps; every phase starts with a write, which
      // also restarts any frame cut short before it
      useful_beats = 0;
      phase        = 0;
      while (useful_beats < RANDOM_BEATS) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            w_raw = $urandom_range(1, 8);
            h_raw = $urandom_range(1, 6);
         end else if (roll < 85) begin
            w_raw = $urandom_range(9, 40);
            h_raw = $urandom_range(1, 3);
         end else if (roll < 93) begin
            w_raw = $urandom_range(1, 4);
            h_raw = $urandom_range(8, 20);
         end else begin
            // degenerate maps, zero registers among them
            w_raw = $urandom_range(0, 1);
            h_raw = $urandom_range(0, 3);
         end

         wait_results_drained();
         idle_on = ($urandom_range(99) < 80);
         if ($urandom_range(99) < 5)
            write_reg(($urandom_range(1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      DIM_BITS'($urandom));
         roll = (phase == 0) ? 0 : $urandom_range(2);
         if (roll != 2) write_reg(CSR_ROW_WIDTH, DIM_BITS'(w_raw));
         if (roll != 1) write_reg(CSR_FRAME_HEIGHT, DIM_BITS'(h_raw));

         // once: receiver holds off while beats keep coming
         if (phase == 2) begin
            idle_on = 1'b0;
            hold_off_requests++;
         end

         frames = $urandom_range(1, 3);
         repeat (frames) begin
            cut = ($urandom_range(99) < 8);
            send_frame(cur_w, cur_h, cut);
            if (cut) break;
            // sender pauses until everything owed has come back
            if ($urandom_range(99) < 10) wait_results_drained();
         end
         phase++;
      end

      // tail: all owed results, then a quiet spell for anything unexpected
      wait_results_drained();
      repeat (20) @(negedge clock);
      if (awaited_pixels.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, awaited_pixels.size());
         failures++;
      end

      $display("Run: %0d beats taken, %0d ignored, %0d register writes, %0d random phases.",
               beats_taken, beats_ignored, reg_writes, phase);
      $display("Compared %0d smoothed results, maps from 1x1 up to 4096 wide and 4096 high.",
               results_seen);
      if (failures == 0) begin
         $display("edge_aware_box_smooth_3x3_core verification clean");
      end else begin
         $display("edge_aware_box_smooth_3x3_core verification failed");
      end
      $finish;
   end

endmodule
